// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on aclk and disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FDR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define FDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: design/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg
// shared types and constants of the fresnel reflectance pipeline
// ----------------------------------------------------------------------------
package fdr_pkg;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_I = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_T = 1'b1;

    localparam logic [15:0] ETA_I_RESET = 16'd4096;
    localparam logic [15:0] ETA_T_RESET = 16'd6144;

    // fixed point ones and the Q46 rounding half
    localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
    localparam logic [28:0]        ONE_Q28  = 29'h1000_0000;
    localparam logic [30:0]        ONE_Q30  = 31'h4000_0000;
    localparam logic [15:0]        ONE_Q15  = 16'h8000;
    localparam logic [62:0]        HALF_Q46 = 63'h0000_2000_0000_0000;

    // item context carried beside the arithmetic
    typedef struct packed {
        logic [14:0] c;
        logic [15:0] ni;
        logic [15:0] nt;
        logic        tir;
    } ctx_t;

    // flags beside the parallel ratio divider
    typedef struct packed {
        logic tir;
        logic zp;
    } rflag_t;

endpackage

// File: design/fdr_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// fdr_sqrt_pipe
// integer square root (floor), one result bit per register stage
// ----------------------------------------------------------------------------
module fdr_sqrt_pipe #(
    parameter int VW = 29,
    parameter int SW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [VW-1:0]           in_val,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    output logic [(VW+1)/2-1:0]     out_root,
    output logic [SW-1:0]           out_side
);
    localparam int STEPS = (VW + 1) / 2;
    localparam int XW    = VW + 1;

    logic [XW-1:0] v_reg     [1:STEPS];
    logic [XW-1:0] res_reg   [1:STEPS];
    logic [SW-1:0] side_reg  [1:STEPS];
    logic          valid_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (STEPS - 1 - k));
        logic [XW-1:0] v_cur;
        logic [XW-1:0] res_cur;
        logic [SW-1:0] side_cur;
        logic          valid_cur;
        logic [XW-1:0] trial;
        logic          ge;
        logic [XW-1:0] v_next;
        logic [XW-1:0] res_next;

        if (k == 0) begin : g_first
            assign v_cur     = XW'(in_val);
            assign res_cur   = '0;
            assign side_cur  = in_side;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign v_cur     = v_reg[k];
            assign res_cur   = res_reg[k];
            assign side_cur  = side_reg[k];
            assign valid_cur = valid_reg[k];
        end

        // try the current bit against the remainder
        always_comb begin
            trial    = res_cur + BIT;
            ge       = (v_cur >= trial);
            v_next   = ge ? (v_cur - trial) : v_cur;
            res_next = ge ? ((res_cur >> 1) + BIT) : (res_cur >> 1);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1]    <= v_next;
                res_reg[k+1]  <= res_next;
                side_reg[k+1] <= side_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_cur;
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_root  = res_reg[STEPS][STEPS-1:0];
    assign out_side  = side_reg[STEPS];

endmodule

// File: design/fdr_div_pipe.sv
// ----------------------------------------------------------------------------
// fdr_div_pipe
// restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module fdr_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 28,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [DW-1:0] den_in,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    logic [DW-1:0] rem_reg   [1:QW];
    logic [QW-1:0] low_reg   [1:QW];
    logic [DW-1:0] den_reg   [1:QW];
    logic [SW-1:0] side_reg  [1:QW];
    logic          valid_reg [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_cur;
        logic [QW-1:0] low_cur;
        logic [DW-1:0] den_cur;
        logic [SW-1:0] side_cur;
        logic          valid_cur;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;

        if (k == 0) begin : g_first
            assign rem_cur   = rem_in;
            assign low_cur   = low_in;
            assign den_cur   = den_in;
            assign side_cur  = in_side;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign rem_cur   = rem_reg[k];
            assign low_cur   = low_reg[k];
            assign den_cur   = den_reg[k];
            assign side_cur  = side_reg[k];
            assign valid_cur = valid_reg[k];
        end

        // shift in the next numerator bit, subtract when it fits
        always_comb begin
            sh       = {rem_cur, low_cur[QW-1]};
            diff     = sh - {1'b0, den_cur};
            ge       = (sh >= {1'b0, den_cur});
            rem_next = ge ? diff[DW-1:0] : sh[DW-1:0];
            low_next = {low_cur[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= low_next;
                den_reg[k+1]  <= den_cur;
                side_reg[k+1] <= side_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_cur;
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_quo   = low_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

// File: design/fresnel_dielectric_reflectance.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance: unpolarized dielectric fresnel pipeline
// throughput: one beat per cycle while the result beat is not stalled;
// each root and divide bit is its own stage
// reset: pipeline empties, indices return to 1.0 incident and 1.5 transmitted
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fresnel_dielectric_reflectance (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_cos_incident,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_reflectance,
    output logic                           m_total_internal,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);
    import fdr_pkg::*;

    logic en;

    // configuration registers
    logic [15:0] eta_i_reg;
    logic [15:0] eta_t_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_i_reg <= ETA_I_RESET;
            eta_t_reg <= ETA_T_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ETA_I: eta_i_reg <= cfg_data;
                CFG_ETA_T: eta_t_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the result beat is stuck
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // stage a: clamp, swap on exit side, absolute cosine
    logic signed [15:0] cs_clamp;
    logic               leaving;
    ctx_t               a_ctx_next;
    ctx_t               a_ctx_reg;
    logic               a_valid_reg;

    always_comb begin
        if (s_cos_incident > ONE_Q14) begin
            cs_clamp = ONE_Q14;
        end else if (s_cos_incident < -ONE_Q14) begin
            cs_clamp = -ONE_Q14;
        end else begin
            cs_clamp = s_cos_incident;
        end
        leaving        = (cs_clamp <= 16'sd0);
        a_ctx_next.c   = leaving ? 15'(-cs_clamp) : 15'(cs_clamp);
        a_ctx_next.ni  = leaving ? eta_t_reg : eta_i_reg;
        a_ctx_next.nt  = leaving ? eta_i_reg : eta_t_reg;
        a_ctx_next.tir = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctx_reg <= a_ctx_next;
        end
    end

    // stage b: 1 - c^2
    logic [29:0] csq;
    logic [28:0] b_v1_reg;
    ctx_t        b_ctx_reg;
    logic        b_valid_reg;

    assign csq = a_ctx_reg.c * a_ctx_reg.c;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_v1_reg  <= 29'(30'(ONE_Q28) - csq);
            b_ctx_reg <= a_ctx_reg;
        end
    end

    // sin of incidence
    logic        s1_valid;
    logic [14:0] sin_i;
    ctx_t        s1_ctx;

    fdr_sqrt_pipe #(.VW(29), .SW($bits(ctx_t))) u_sqrt_sin_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_val    (b_v1_reg),
        .in_side   (b_ctx_reg),
        .out_valid (s1_valid),
        .out_root  (sin_i),
        .out_side  (s1_ctx)
    );

    // stage p: ni * sinI
    logic [30:0] p_prod_reg;
    ctx_t        p_ctx_reg;
    logic        p_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_prod_reg <= s1_ctx.ni * sin_i;
            p_ctx_reg  <= s1_ctx;
        end
    end

    // stage q: total internal reflection test, squares for snell
    logic [59:0] q_num_reg;
    logic [31:0] q_den_reg;
    ctx_t        q_ctx_next;
    ctx_t        q_ctx_reg;
    logic        q_valid_reg;

    always_comb begin
        q_ctx_next     = p_ctx_reg;
        q_ctx_next.tir = (p_prod_reg >= {1'b0, p_ctx_reg.nt, 14'b0});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_num_reg <= p_prod_reg[29:0] * p_prod_reg[29:0];
            q_den_reg <= p_ctx_reg.nt * p_ctx_reg.nt;
            q_ctx_reg <= q_ctx_next;
        end
    end

    // sinT^2 by division
    logic        d1_valid;
    logic [27:0] sin_t2;
    ctx_t        d1_ctx;

    fdr_div_pipe #(.DW(32), .QW(28), .SW($bits(ctx_t))) u_div_sin_t2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid_reg),
        .rem_in    (q_num_reg[59:28]),
        .low_in    (q_num_reg[27:0]),
        .den_in    (q_den_reg),
        .in_side   (q_ctx_reg),
        .out_valid (d1_valid),
        .out_quo   (sin_t2),
        .out_side  (d1_ctx)
    );

    // stage v: 1 - sinT^2
    logic [28:0] v_v2_reg;
    ctx_t        v_ctx_reg;
    logic        v_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            v_v2_reg  <= ONE_Q28 - {1'b0, sin_t2};
            v_ctx_reg <= d1_ctx;
        end
    end

    // cos of transmission
    logic        s2_valid;
    logic [14:0] cos_t;
    ctx_t        s2_ctx;

    fdr_sqrt_pipe #(.VW(29), .SW($bits(ctx_t))) u_sqrt_cos_t (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_valid_reg),
        .in_val    (v_v2_reg),
        .in_side   (v_ctx_reg),
        .out_valid (s2_valid),
        .out_root  (cos_t),
        .out_side  (s2_ctx)
    );

    // stage m: the four index-cosine products
    logic [30:0] m_ap_reg;
    logic [30:0] m_bp_reg;
    logic [30:0] m_as_reg;
    logic [30:0] m_bs_reg;
    logic        m_tir_reg;
    logic        m_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_ap_reg  <= s2_ctx.nt * s2_ctx.c;
            m_bp_reg  <= s2_ctx.ni * cos_t;
            m_as_reg  <= s2_ctx.ni * s2_ctx.c;
            m_bs_reg  <= s2_ctx.nt * cos_t;
            m_tir_reg <= s2_ctx.tir;
        end
    end

    // stage n: numerator magnitudes and denominators
    logic [30:0] n_mag_p_reg;
    logic [31:0] n_den_p_reg;
    logic [30:0] n_mag_s_reg;
    logic [31:0] n_den_s_reg;
    logic        n_tir_reg;
    logic        n_valid_reg;
    rflag_t      n_flag;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_mag_p_reg <= (m_ap_reg >= m_bp_reg) ? (m_ap_reg - m_bp_reg)
                                                  : (m_bp_reg - m_ap_reg);
            n_den_p_reg <= {1'b0, m_ap_reg} + {1'b0, m_bp_reg};
            n_mag_s_reg <= (m_as_reg >= m_bs_reg) ? (m_as_reg - m_bs_reg)
                                                  : (m_bs_reg - m_as_reg);
            n_den_s_reg <= {1'b0, m_as_reg} + {1'b0, m_bs_reg};
            n_tir_reg   <= m_tir_reg;
        end
    end

    assign n_flag.tir = n_tir_reg;
    assign n_flag.zp  = (n_den_p_reg == 32'd0);

    // amplitude ratios in q30
    logic        rp_valid;
    logic [30:0] rp_quo;
    rflag_t      rp_flag;
    logic        rs_valid;
    logic [30:0] rs_quo;
    logic        rs_zero;

    fdr_div_pipe #(.DW(32), .QW(31), .SW($bits(rflag_t))) u_div_rp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid_reg),
        .rem_in    ({2'b0, n_mag_p_reg[30:1]}),
        .low_in    ({n_mag_p_reg[0], 30'b0}),
        .den_in    (n_den_p_reg),
        .in_side   (n_flag),
        .out_valid (rp_valid),
        .out_quo   (rp_quo),
        .out_side  (rp_flag)
    );

    fdr_div_pipe #(.DW(32), .QW(31), .SW(1)) u_div_rs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid_reg),
        .rem_in    ({2'b0, n_mag_s_reg[30:1]}),
        .low_in    ({n_mag_s_reg[0], 30'b0}),
        .den_in    (n_den_s_reg),
        .in_side   (n_den_s_reg == 32'd0),
        .out_valid (rs_valid),
        .out_quo   (rs_quo),
        .out_side  (rs_zero)
    );

    // stage r: squared ratios, a zero denominator counts as one
    logic [30:0] rp_sel;
    logic [30:0] rs_sel;
    logic [61:0] r_sqp_reg;
    logic [61:0] r_sqs_reg;
    logic        r_tir_reg;
    logic        r_valid_reg;

    assign rp_sel = rp_flag.zp ? ONE_Q30 : rp_quo;
    assign rs_sel = rs_zero ? ONE_Q30 : rs_quo;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_sqp_reg <= rp_sel * rp_sel;
            r_sqs_reg <= rs_sel * rs_sel;
            r_tir_reg <= rp_flag.tir;
        end
    end

    // output stage: mean with rounding, saturate, tir override
    logic [62:0] sum;
    logic [16:0] refl_raw;
    logic [15:0] refl_next;
    logic [15:0] out_refl_reg;
    logic        out_tir_reg;

    always_comb begin
        sum       = {1'b0, r_sqp_reg} + {1'b0, r_sqs_reg} + HALF_Q46;
        refl_raw  = sum[62:46];
        refl_next = (refl_raw > {1'b0, ONE_Q15}) ? ONE_Q15 : refl_raw[15:0];
        if (r_tir_reg) begin
            refl_next = ONE_Q15;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_refl_reg <= refl_next;
            out_tir_reg  <= r_tir_reg;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            v_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= s_valid;
            b_valid_reg   <= a_valid_reg;
            p_valid_reg   <= s1_valid;
            q_valid_reg   <= p_valid_reg;
            v_valid_reg   <= d1_valid;
            m_valid_reg   <= s2_valid;
            n_valid_reg   <= m_valid_reg;
            r_valid_reg   <= rp_valid && rs_valid;
            out_valid_reg <= r_valid_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_reflectance    = out_refl_reg;
    assign m_total_internal = out_tir_reg;

    // checks
    `FDR_ASSERT_IMPL(a_tir_full, m_valid && m_total_internal, m_reflectance == ONE_Q15)
    `FDR_ASSERT_IMPL(a_refl_range, m_valid, m_reflectance <= ONE_Q15)
    `FDR_ASSERT_IMPL(a_ratio_lanes, rp_valid || rs_valid, rp_valid && rs_valid)
    `FDR_ASSERT_NEXT(a_stall_holds, !s_ready, $stable(r_valid_reg) && m_valid)

endmodule

// File: bench/fresnel_dielectric_reflectance_tb.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_tb
// streams incident cosines through the fresnel pipeline under several index
// settings, with random gaps and stalls, and checks each reflectance beat
// against an in-bench fixed point prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_tb;
    import fdr_pkg::*;

    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_ITEMS  = 190;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [15:0] refl;
        logic        tir;
    } fresnel_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [15:0]   s_cos_incident;
    logic                 m_valid;
    logic                 m_ready;
    logic [15:0]          m_reflectance;
    logic                 m_total_internal;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    logic signed [15:0] pending_cos[$];
    fresnel_result_t    expected_refl[$];
    logic [15:0]        eta_in;
    logic [15:0]        eta_out;
    bit                 idle_on;
    int                 fail_count;
    int                 cycle_count;

    fresnel_dielectric_reflectance DUT (.*);

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // amplitude ratio magnitude in Q30, zero denominator gives one
    function automatic longint unsigned amp_ratio(longint signed num, longint signed den);
        longint unsigned mag;
        mag = (num < 0) ? -num : num;
        if (den <= 0) return 64'd1 << 30;
        return (mag << 30) / den;
    endfunction

    function automatic fresnel_result_t predict_fresnel(logic signed [15:0] cosv,
                                                        logic [15:0] eta_a,
                                                        logic [15:0] eta_b);
        fresnel_result_t r;
        longint signed   cs;
        longint unsigned ni, nt, tmp, c, sin_i, sin_t2, cos_t, rp, rs, refl;
        cs = cosv;
        ni = eta_a;
        nt = eta_b;
        if (cs > 16384) cs = 16384;
        if (cs < -16384) cs = -16384;
        // leaving the medium: swap sides
        if (cs <= 0) begin
            tmp = ni;
            ni = nt;
            nt = tmp;
            cs = -cs;
        end
        c = cs;
        sin_i = sqrt_floor((64'd1 << 28) - c * c);
        if (ni * sin_i >= nt * 64'd16384) begin
            r.refl = ONE_Q15;
            r.tir = 1'b1;
            return r;
        end
        sin_t2 = (ni * ni * sin_i * sin_i) / (nt * nt);
        if (sin_t2 > (64'd1 << 28)) sin_t2 = 64'd1 << 28;
        cos_t = sqrt_floor((64'd1 << 28) - sin_t2);
        rp = amp_ratio(longint'(nt * c) - longint'(ni * cos_t),
                       longint'(nt * c) + longint'(ni * cos_t));
        rs = amp_ratio(longint'(ni * c) - longint'(nt * cos_t),
                       longint'(ni * c) + longint'(nt * cos_t));
        if (rp > (64'd1 << 30)) rp = 64'd1 << 30;
        if (rs > (64'd1 << 30)) rs = 64'd1 << 30;
        refl = (rp * rp + rs * rs + (64'd1 << 45)) >> 46;
        if (refl > 64'd32768) refl = 64'd32768;
        r.refl = refl[15:0];
        r.tir = 1'b0;
        return r;
    endfunction

    // input driver: one cosine beat per pending entry, random gaps between
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            bit taken;
            taken = s_valid && s_ready;
            if (taken) begin
                expected_refl.push_back(predict_fresnel(s_cos_incident, eta_in, eta_out));
                void'(pending_cos.pop_front());
                send_gap = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (s_valid && !taken) begin
                s_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_cos.size() > 0) begin
                s_valid <= 1'b1;
                s_cos_incident <= pending_cos[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor: compare each beat, random stalls plus one long hold-off
    int stall_left;
    int hold_left;
    int results_seen;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            results_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_refl.size() == 0) begin
                    $display("%0t: unexpected result refl=%0d tir=%0b",
                             $time, m_reflectance, m_total_internal);
                    fail_count++;
                end else begin
                    fresnel_result_t e;
                    e = expected_refl.pop_front();
                    if (m_reflectance !== e.refl) begin
                        $display("%0t: reflectance expected %0d actual %0d",
                                 $time, e.refl, m_reflectance);
                        fail_count++;
                    end
                    if (m_total_internal !== e.tir) begin
                        $display("%0t: total_internal expected %0b actual %0b",
                                 $time, e.tir, m_total_internal);
                        fail_count++;
                    end
                end
                results_seen++;
                stall_left = idle_on ? $urandom_range(0, 16) : 0;
                if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cos.size() != 0 || s_valid || expected_refl.size() != 0);
    endtask

    task automatic write_index(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ETA_I) eta_in = val;
        else eta_out = val;
    endtask

    function automatic logic signed [15:0] random_cos();
        unique case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 32768) - 16384);
            2: return 16'($urandom_range(0, 400) - 200);
            3: return 16'(($urandom_range(0, 1) ? 16384 : -16384)
                          + $urandom_range(0, 60) - 30);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // index settings per phase, the first keeps the reset values
    logic [15:0] phase_eta_i[PHASE_COUNT] =
        '{16'd4096, 16'd4096, 16'd6144, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd4096, 16'd1};
    logic [15:0] phase_eta_t[PHASE_COUNT] =
        '{16'd6144, 16'd6144, 16'd4096, 16'd1, 16'd65535, 16'd65535, 16'd6144, 16'd0, 16'd1};
    logic signed [15:0] directed_cos[] = '{16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768,
        16'sd0, 16'sd1, -16'sd1, 16'sd16383, -16'sd16383, 16'sd16385, -16'sd16385,
        16'sd11585, -16'sd11585, 16'sd8192, -16'sd8192, 16'sd100, -16'sd100,
        16'sh5555, -16'sh5556, 16'sd2000, -16'sd2000};

    // stimulus sequencing
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cos_incident = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ETA_I;
        cfg_data = '0;
        eta_in = ETA_I_RESET;
        eta_out = ETA_T_RESET;
        idle_on = 1'b1;
        fail_count = 0;
        cycle_count = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                // sender pauses until the pipeline is empty before reconfiguring
                wait_drained();
                repeat (DRAIN_CYCLES) @(posedge aclk);
                write_index(CFG_ETA_I, phase_eta_i[p]);
                write_index(CFG_ETA_T, phase_eta_t[p]);
            end
            @(negedge aclk);
            idle_on = (p % 3 != 1);
            foreach (directed_cos[k])
                if (p == 0 || k < 7) pending_cos.push_back(directed_cos[k]);
            for (int k = 0; k < PHASE_ITEMS; k++) pending_cos.push_back(random_cos());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: fresnel_dielectric_reflectance.f
+incdir+design
design/fdr_pkg.sv
design/fdr_sqrt_pipe.sv
design/fdr_div_pipe.sv
design/fresnel_dielectric_reflectance.sv
bench/fresnel_dielectric_reflectance_tb.sv
